/* design/mvp_pkg.sv */
// Shared types, constants, message table and CRC helpers for the MAVLink v2 frame parser.
package mvp_pkg;

  localparam int PAYLOAD_DEPTH_DEF = 256;
  localparam int TABLE_ROWS_DEF    = 15;
  localparam int COUNT_WIDTH_DEF   = 32;
  localparam int ROM_ROWS          = 15;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [7:0]  START_BYTE = 8'hFD;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CRC_ERR  = 2'd1;
  localparam logic [1:0] ST_UNKNOWN  = 2'd2;
  localparam logic [1:0] ST_SIGNED   = 2'd3;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  // Work handed from the parser to the back end
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  addr;
    logic [7:0]  data;
    logic [23:0] msg;
    logic [7:0]  sys;
    logic [7:0]  comp;
    logic [7:0]  len;
    logic        signed_frame;
    logic [15:0] crc;
    logic [15:0] rx_crc;
  } cmd_t;

  typedef struct packed {
    logic [23:0] id;
    logic [7:0]  extra;
    logic [7:0]  len;
  } rom_row_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] extra;
    logic [7:0] len;
  } lookup_t;

  localparam rom_row_t MSG_ROM [ROM_ROWS] = '{
    '{24'd0,   8'd50,  8'd9},   '{24'd1,   8'd124, 8'd31},  '{24'd24,  8'd24,  8'd52},
    '{24'd30,  8'd39,  8'd28},  '{24'd33,  8'd104, 8'd28},  '{24'd65,  8'd118, 8'd42},
    '{24'd70,  8'd124, 8'd38},  '{24'd76,  8'd152, 8'd33},  '{24'd77,  8'd143, 8'd10},
    '{24'd82,  8'd49,  8'd39},  '{24'd84,  8'd143, 8'd53},  '{24'd102, 8'd158, 8'd117},
    '{24'd103, 8'd208, 8'd57},  '{24'd193, 8'd71,  8'd22},  '{24'd253, 8'd83,  8'd54}
  };

  function automatic logic [15:0] crc_step(input logic [7:0] b, input logic [15:0] c);
    logic [7:0] t;
    t = b ^ c[7:0];
    t = t ^ (t << 4);
    return {8'h00, c[15:8]} ^ {t, 8'h00} ^ {5'h00, t, 3'h0} ^ {12'h000, t[7:4]};
  endfunction

  // First matching row among the searched rows wins
  function automatic lookup_t rom_lookup(input logic [23:0] id, input int rows);
    lookup_t r;
    r = '0;
    for (int i = ROM_ROWS - 1; i >= 0; i--) begin
      if (i < rows && MSG_ROM[i].id == id) begin
        r.hit   = 1'b1;
        r.extra = MSG_ROM[i].extra;
        r.len   = MSG_ROM[i].len;
      end
    end
    return r;
  endfunction

endpackage

/* design/mvp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mvp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/mvp_front.sv */
// Byte parser: tracks frame phase and running CRC, emits write/read/end commands.
module mvp_front #(
  parameter int PAYLOAD_DEPTH = mvp_pkg::PAYLOAD_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          opcode,
  input  logic [7:0]    data_byte,
  input  logic [7:0]    read_index,
  input  logic          q_full,
  output logic          push,
  output mvp_pkg::cmd_t cmd
);

  localparam logic [3:0] PH_START    = 4'd0;
  localparam logic [3:0] PH_LEN      = 4'd1;
  localparam logic [3:0] PH_INCOMPAT = 4'd2;
  localparam logic [3:0] PH_COMPAT   = 4'd3;
  localparam logic [3:0] PH_SEQ      = 4'd4;
  localparam logic [3:0] PH_SYS      = 4'd5;
  localparam logic [3:0] PH_COMP     = 4'd6;
  localparam logic [3:0] PH_MSGID    = 4'd7;
  localparam logic [3:0] PH_PAYLOAD  = 4'd8;
  localparam logic [3:0] PH_CRC      = 4'd9;

  logic [3:0]  phase, phase_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  len, len_next;
  logic        sig, sig_next;
  logic [7:0]  sys, sys_next;
  logic [7:0]  comp, comp_next;
  logic [23:0] msg, msg_next;
  logic [7:0]  pos, pos_next;
  logic [7:0]  rx_lo, rx_lo_next;
  logic        accept;
  logic [15:0] crc_b;
  logic [8:0]  pos_inc;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign crc_b    = mvp_pkg::crc_step(data_byte, crc);
  assign pos_inc  = {1'b0, pos} + 9'd1;

  always_comb begin
    phase_next = phase;
    crc_next   = crc;
    len_next   = len;
    sig_next   = sig;
    sys_next   = sys;
    comp_next  = comp;
    msg_next   = msg;
    pos_next   = pos;
    rx_lo_next = rx_lo;
    push       = 1'b0;
    cmd        = '0;
    cmd.msg    = msg;
    cmd.sys    = sys;
    cmd.comp   = comp;
    cmd.len    = len;
    cmd.signed_frame = sig;
    cmd.crc    = crc;
    cmd.rx_crc = {data_byte, rx_lo};
    if (accept && opcode == mvp_pkg::OP_READ) begin
      push     = 1'b1;
      cmd.op   = mvp_pkg::CMD_READ;
      cmd.data = read_index;
    end else if (accept) begin
      case (phase)
        PH_LEN: begin
          len_next = data_byte; crc_next = crc_b; phase_next = PH_INCOMPAT;
        end
        PH_INCOMPAT: begin
          sig_next = data_byte[0]; crc_next = crc_b; phase_next = PH_COMPAT;
        end
        PH_COMPAT: begin
          crc_next = crc_b; phase_next = PH_SEQ;
        end
        PH_SEQ: begin
          crc_next = crc_b; phase_next = PH_SYS;
        end
        PH_SYS: begin
          sys_next = data_byte; crc_next = crc_b; phase_next = PH_COMP;
        end
        PH_COMP: begin
          comp_next = data_byte; crc_next = crc_b;
          pos_next = '0; msg_next = '0; phase_next = PH_MSGID;
        end
        PH_MSGID: begin
          crc_next = crc_b;
          case (pos[1:0])
            2'd0:    msg_next[7:0]   = data_byte;
            2'd1:    msg_next[15:8]  = data_byte;
            default: msg_next[23:16] = data_byte;
          endcase
          pos_next = pos_inc[7:0];
          if (pos_inc >= 9'd3) begin
            pos_next   = '0;
            phase_next = (len != 8'd0) ? PH_PAYLOAD : PH_CRC;
          end
        end
        PH_PAYLOAD: begin
          crc_next = crc_b;
          // drop bytes past the store
          if ({1'b0, pos} < 9'(PAYLOAD_DEPTH)) begin
            push     = 1'b1;
            cmd.op   = mvp_pkg::CMD_WRITE;
            cmd.addr = pos;
            cmd.data = data_byte;
          end
          pos_next = pos_inc[7:0];
          if (pos_inc >= {1'b0, len}) begin
            pos_next = '0; phase_next = PH_CRC;
          end
        end
        PH_CRC: begin
          if (pos == 8'd0) begin
            rx_lo_next = data_byte; pos_next = 8'd1;
          end else begin
            push       = 1'b1;
            cmd.op     = mvp_pkg::CMD_END;
            pos_next   = '0;
            phase_next = PH_START;
          end
        end
        default: begin
          phase_next = PH_START;
          if (data_byte == mvp_pkg::START_BYTE) begin
            phase_next = PH_LEN;
            crc_next   = mvp_pkg::CRC_INIT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      crc   <= mvp_pkg::CRC_INIT;
      len   <= '0;
      sig   <= 1'b0;
      sys   <= '0;
      comp  <= '0;
      msg   <= '0;
      pos   <= '0;
      rx_lo <= '0;
    end else begin
      phase <= phase_next;
      crc   <= crc_next;
      len   <= len_next;
      sig   <= sig_next;
      sys   <= sys_next;
      comp  <= comp_next;
      msg   <= msg_next;
      pos   <= pos_next;
      rx_lo <= rx_lo_next;
    end
  end

endmodule

/* design/mvp_queue.sv */
// Short command FIFO between the parser and the back end.
module mvp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mvp_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          not_empty,
  input  logic          pop,
  output mvp_pkg::cmd_t head
);

  localparam int PW = $clog2(mvp_pkg::QUEUE_DEPTH);

  mvp_pkg::cmd_t slots [mvp_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign full      = (count == (PW+1)'(mvp_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

/* design/mvp_back.sv */
// Back end: payload store, table check, counters and the output register.
module mvp_back #(
  parameter int PAYLOAD_DEPTH = mvp_pkg::PAYLOAD_DEPTH_DEF,
  parameter int TABLE_ROWS    = mvp_pkg::TABLE_ROWS_DEF,
  parameter int COUNT_WIDTH   = mvp_pkg::COUNT_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  mvp_pkg::cmd_t q_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          kind,
  output logic [1:0]    status,
  output logic [23:0]   message_id,
  output logic [7:0]    system_id,
  output logic [7:0]    component_id,
  output logic [7:0]    full_length,
  output logic [7:0]    received_length,
  output logic [31:0]   good_frames,
  output logic [31:0]   crc_errors,
  output logic [7:0]    read_data,
  output logic          read_in_range
);

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  logic [COUNT_WIDTH-1:0] good_cnt, good_cnt_next;
  logic [COUNT_WIDTH-1:0] err_cnt, err_cnt_next;
  logic [7:0]  last_full, last_full_next;
  logic [7:0]  last_recv, last_recv_next;
  logic        res_valid;
  logic        res_gate;
  logic [7:0]  ram_rdata;
  logic        produce;
  logic        ram_we, ram_re;
  logic [1:0]  st;
  logic [7:0]  full;
  mvp_pkg::lookup_t hit;
  logic [15:0] crc_final;

  assign pop       = q_valid && (!res_valid || !out_stall);
  assign produce   = pop && (q_cmd.op == mvp_pkg::CMD_READ || q_cmd.op == mvp_pkg::CMD_END);
  assign ram_we    = pop && q_cmd.op == mvp_pkg::CMD_WRITE;
  assign ram_re    = pop && q_cmd.op == mvp_pkg::CMD_READ;
  assign hit       = mvp_pkg::rom_lookup(q_cmd.msg, TABLE_ROWS);
  assign crc_final = mvp_pkg::crc_step(hit.extra, q_cmd.crc);
  assign out_valid = res_valid;
  assign read_data = (kind == mvp_pkg::KIND_READ && res_gate) ? ram_rdata : 8'h00;

  mvp_ram #(.WIDTH(8), .DEPTH(PAYLOAD_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_cmd.addr[AW-1:0]),
    .wdata (q_cmd.data),
    .re    (ram_re),
    .raddr (q_cmd.data[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    good_cnt_next  = good_cnt;
    err_cnt_next   = err_cnt;
    last_full_next = last_full;
    last_recv_next = last_recv;
    st             = mvp_pkg::ST_OK;
    full           = hit.hit ? hit.len : 8'h00;
    if (!hit.hit) begin
      st = mvp_pkg::ST_UNKNOWN;
    end else if (q_cmd.signed_frame) begin
      st = mvp_pkg::ST_SIGNED;
    end else if (crc_final != q_cmd.rx_crc) begin
      st = mvp_pkg::ST_CRC_ERR;
      if (pop && q_cmd.op == mvp_pkg::CMD_END) err_cnt_next = err_cnt + 1'b1;
    end else if (pop && q_cmd.op == mvp_pkg::CMD_END) begin
      good_cnt_next  = good_cnt + 1'b1;
      last_full_next = hit.len;
      last_recv_next = q_cmd.len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      good_cnt  <= '0;
      err_cnt   <= '0;
      last_full <= '0;
      last_recv <= '0;
    end else begin
      if (res_valid && !out_stall) res_valid <= 1'b0;
      if (produce) res_valid <= 1'b1;
      good_cnt  <= good_cnt_next;
      err_cnt   <= err_cnt_next;
      last_full <= last_full_next;
      last_recv <= last_recv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      good_frames <= 32'(good_cnt_next);
      crc_errors  <= 32'(err_cnt_next);
      if (q_cmd.op == mvp_pkg::CMD_READ) begin
        kind            <= mvp_pkg::KIND_READ;
        status          <= mvp_pkg::ST_OK;
        message_id      <= '0;
        system_id       <= '0;
        component_id    <= '0;
        full_length     <= last_full;
        received_length <= last_recv;
        read_in_range   <= q_cmd.data < last_full;
        res_gate        <= q_cmd.data < last_full && q_cmd.data < last_recv &&
                           {1'b0, q_cmd.data} < 9'(PAYLOAD_DEPTH);
      end else begin
        kind            <= mvp_pkg::KIND_REPORT;
        status          <= st;
        message_id      <= q_cmd.msg;
        system_id       <= q_cmd.sys;
        component_id    <= q_cmd.comp;
        full_length     <= full;
        received_length <= q_cmd.len;
        read_in_range   <= 1'b0;
        res_gate        <= 1'b0;
      end
    end
  end

endmodule

/* design/mavlink_v2_frame_parser_core.sv */
// Top level of the MAVLink v2 receive frame parser.
// Each input word either feeds one received link byte (opcode 0) or reads one
// payload byte of the last good frame (opcode 1). The parser front end takes a
// word every cycle unless the command queue is full: it follows the frame phases,
// folds each header and payload byte into the X.25 CRC and sends payload writes,
// read requests and end-of-frame checks into a four-entry command queue. The back
// end drains one command per cycle while its output register is not held by a stall,
// writes or reads the payload RAM, looks up the message table, finishes the
// CRC with the message's extra byte and keeps the wrapping good-frame and
// CRC-error counters. One result word appears per frame end and per read;
// results leave through an output register, so the block keeps taking words
// while a result waits. Sustained rate is one word per cycle while nothing stalls;
// a word's result passes through its queue entry and then the output register,
// with the RAM read registered on the same edge as the output register. Signed
// frames are reported as refused and their signature bytes are scanned as line noise.
module mavlink_v2_frame_parser_core #(
  parameter int PAYLOAD_DEPTH = mvp_pkg::PAYLOAD_DEPTH_DEF,
  parameter int TABLE_ROWS    = mvp_pkg::TABLE_ROWS_DEF,
  parameter int COUNT_WIDTH   = mvp_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  read_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        kind,
  output logic [1:0]  status,
  output logic [23:0] message_id,
  output logic [7:0]  system_id,
  output logic [7:0]  component_id,
  output logic [7:0]  full_length,
  output logic [7:0]  received_length,
  output logic [31:0] good_frames,
  output logic [31:0] crc_errors,
  output logic [7:0]  read_data,
  output logic        read_in_range
);

  logic          q_full, q_not_empty, push, pop;
  mvp_pkg::cmd_t push_cmd, head;

  // Front end: classify each word, hold when the queue is full
  mvp_front #(.PAYLOAD_DEPTH(PAYLOAD_DEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .data_byte  (data_byte),
    .read_index (read_index),
    .q_full     (q_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  mvp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (pop),
    .head      (head)
  );

  // Back end: advance commands in order, drop nothing
  mvp_back #(
    .PAYLOAD_DEPTH (PAYLOAD_DEPTH),
    .TABLE_ROWS    (TABLE_ROWS),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_not_empty),
    .q_cmd           (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .status          (status),
    .message_id      (message_id),
    .system_id       (system_id),
    .component_id    (component_id),
    .full_length     (full_length),
    .received_length (received_length),
    .good_frames     (good_frames),
    .crc_errors      (crc_errors),
    .read_data       (read_data),
    .read_in_range   (read_in_range)
  );

endmodule
